[design/cta_pkg.sv]
// cta_pkg: shared types, constants and the CORDIC arctangent table for the
// corner tangent arc block. No dependencies.
`timescale 1ns / 1ps

package cta_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int CORDIC_STEPS    = 30;

    localparam logic [30:0] RADIUS_RESET = 31'(1 << COORD_FRAC_BITS);

    // pi in Q30 radians
    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

    // distance limit 2^40 - 1; quotient carries one spare bit for overflow
    localparam int DIST_BITS = 40;
    localparam int QUOT_BITS = DIST_BITS + 1;
    localparam int PROD_W    = 63 + QUOT_BITS + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int HEAD_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [34:0] HEAD_HALF = 35'sd1 <<< (HEAD_SHIFT - 1);

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               path_start;
    } waypoint_t;

    typedef struct packed {
        logic signed [31:0] entry_x;
        logic signed [31:0] entry_y;
        logic signed [31:0] exit_x;
        logic signed [31:0] exit_y;
        logic signed [15:0] heading_in;
        logic signed [15:0] heading_out;
        logic [31:0]        arc_length;
        logic               degenerate;
    } corner_t;

    // one corner handed from the front to the back
    typedef struct packed {
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [32:0] u1x;
        logic signed [32:0] u1y;
        logic signed [32:0] u2x;
        logic signed [32:0] u2y;
        logic               degen;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CLASS,
        BK_NORM_LD,
        BK_NORM_RUN,
        BK_PROD,
        BK_SQ_GO,
        BK_SQ_WAIT,
        BK_NN,
        BK_DEN,
        BK_DIV_GO,
        BK_DIV_WAIT,
        BK_CORD_GO,
        BK_CORD_WAIT,
        BK_ARC,
        BK_RES
    } back_state_t;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_MUL,
        DV_CHK,
        DV_DIV,
        DV_DONE
    } div_state_t;

    // atan(2^-i) in Q30; beyond the table the angle equals 2^(30-i) - 1
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        unique case (i)
            5'd0:    atan_entry = 32'h3243F6A8;
            5'd1:    atan_entry = 32'h1DAC6705;
            5'd2:    atan_entry = 32'h0FADBAFC;
            5'd3:    atan_entry = 32'h07F56EA6;
            5'd4:    atan_entry = 32'h03FEAB76;
            5'd5:    atan_entry = 32'h01FFD55B;
            5'd6:    atan_entry = 32'h00FFFAAA;
            5'd7:    atan_entry = 32'h007FFF55;
            5'd8:    atan_entry = 32'h003FFFEA;
            5'd9:    atan_entry = 32'h001FFFFD;
            5'd10:   atan_entry = 32'h000FFFFF;
            default: atan_entry = (32'd1 << (5'd30 - i)) - 32'd1;
        endcase
    endfunction

endpackage

[design/cta_front.sv]
// cta_front: waypoint window and corner classification.
// Depends on cta_pkg.
`timescale 1ns / 1ps

module cta_front
    import cta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  waypoint_t wp,
    input  logic      push,
    output logic      full,
    input  logic      q_full,
    output logic      job_push,
    output job_t      job
);

    logic signed [31:0] older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic [1:0]         held_reg;
    logic               accept;
    logic               fill;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign fill   = wp.path_start || (held_reg != 2'd2);

    always_comb
    begin
        job.bx    = newer_x_reg;
        job.by    = newer_y_reg;
        job.u1x   = 33'(newer_x_reg) - 33'(older_x_reg);
        job.u1y   = 33'(newer_y_reg) - 33'(older_y_reg);
        job.u2x   = 33'(wp.point_x) - 33'(newer_x_reg);
        job.u2y   = 33'(wp.point_y) - 33'(newer_y_reg);
        job.degen = (job.u1x == '0 && job.u1y == '0) || (job.u2x == '0 && job.u2y == '0);
    end

    assign job_push = accept && !fill;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_x_reg <= '0;
            older_y_reg <= '0;
            newer_x_reg <= '0;
            newer_y_reg <= '0;
            held_reg    <= 2'd0;
        end
        else if (accept)
        begin
            if (wp.path_start || held_reg == 2'd0)
            begin
                held_reg <= 2'd1;
            end
            else
            begin
                older_x_reg <= newer_x_reg;
                older_y_reg <= newer_y_reg;
                held_reg    <= 2'd2;
            end
            newer_x_reg <= wp.point_x;
            newer_y_reg <= wp.point_y;
        end
    end

endmodule

[design/cta_queue.sv]
// cta_queue: short job queue between front and back.
// Depends on cta_pkg.
`timescale 1ns / 1ps

module cta_queue
    import cta_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_en,
    input  job_t push_data,
    output logic full,
    input  logic pop_en,
    output job_t head,
    output logic empty
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push_en && !full;
    assign do_pop  = pop_en && !empty;
    assign head    = mem[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/cta_sqrt.sv]
// cta_sqrt: bit-pair floor square root, one result bit per cycle.
// Depends on cta_pkg.
`timescale 1ns / 1ps

module cta_sqrt
    import cta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] value,
    output logic        done,
    output logic [30:0] root
);

    logic [63:0] v_reg, r_reg, bit_reg;
    logic        busy_reg, done_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;
    assign done  = done_reg;
    assign root  = r_reg[30:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= 64'(value);
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg == 64'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

[design/cta_div.sv]
// cta_div: serial multiply then restoring divide, floor(a*b/c) clamped to
// 2^40 - 1. Depends on cta_pkg.
`timescale 1ns / 1ps

module cta_div
    import cta_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [62:0]          a,
    input  logic [QUOT_BITS-1:0] b,
    input  logic [62:0]          c,
    output logic                 done,
    output logic [DIST_BITS-1:0] q
);

    localparam int CNT_W = $clog2(QUOT_BITS);

    div_state_t           state_reg, state_next;
    logic [62:0]          a_reg, c_reg;
    logic [QUOT_BITS-1:0] b_reg, q_reg;
    logic [PROD_W-1:0]    prod_reg, dsh_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 over;

    // quotient would need more than the spare bit
    assign over = prod_reg >= (PROD_W'(c_reg) << QUOT_BITS);

    always_comb
    begin : next_state
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE: if (start) state_next = DV_MUL;
            DV_MUL:  if (cnt_reg == '0) state_next = DV_CHK;
            DV_CHK:  state_next = over ? DV_DONE : DV_DIV;
            DV_DIV:  if (cnt_reg == '0) state_next = DV_DONE;
            DV_DONE: state_next = DV_IDLE;
            default: state_next = DV_IDLE;
        endcase
    end

    always_comb
    begin : outputs
        done = (state_reg == DV_DONE);
        q    = q_reg[QUOT_BITS-1] ? '1 : q_reg[DIST_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            DV_IDLE:
            begin
                a_reg    <= a;
                b_reg    <= b;
                c_reg    <= c;
                prod_reg <= '0;
                cnt_reg  <= CNT_W'(QUOT_BITS - 1);
            end
            DV_MUL:
            begin
                prod_reg <= (prod_reg << 1) + (b_reg[QUOT_BITS-1] ? PROD_W'(a_reg) : '0);
                b_reg    <= b_reg << 1;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            DV_CHK:
            begin
                q_reg   <= over ? '1 : '0;
                dsh_reg <= PROD_W'(c_reg) << (QUOT_BITS - 1);
                cnt_reg <= CNT_W'(QUOT_BITS - 1);
            end
            DV_DIV:
            begin
                if (prod_reg >= dsh_reg)
                begin
                    prod_reg <= prod_reg - dsh_reg;
                    q_reg    <= {q_reg[QUOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    q_reg <= {q_reg[QUOT_BITS-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            DV_DONE: ;
            default: ;
        endcase
    end

endmodule

[design/cta_cordic.sv]
// cta_cordic: vectoring CORDIC atan2 in Q30 radians, one rotation per cycle.
// Depends on cta_pkg (arctangent table, pi).
`timescale 1ns / 1ps

module cta_cordic
    import cta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [30:0] x_in,
    input  logic signed [30:0] y_in,
    output logic               done,
    output logic signed [33:0] z
);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [4:0]         i_reg;
    logic               busy_reg, done_reg;
    logic signed [33:0] x_ext, y_ext, dx, dy, t;

    assign x_ext = 34'(x_in);
    assign y_ext = 34'(y_in);
    assign dx    = y_reg >>> i_reg;
    assign dy    = x_reg >>> i_reg;
    assign t     = $signed({2'b00, atan_entry(i_reg)});
    assign done  = done_reg;
    assign z     = z_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            i_reg <= '0;
            if (x_ext < 0)
            begin
                // left half plane: fold by pi first
                z_reg <= (y_ext >= 0) ? PI_Q30 : -PI_Q30;
                x_reg <= -x_ext;
                y_reg <= -y_ext;
            end
            else
            begin
                z_reg <= '0;
                x_reg <= x_ext;
                y_reg <= y_ext;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + t;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - t;
            end
            i_reg <= i_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && i_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

[design/cta_back.sv]
// cta_back: corner sequencer; runs normalisation, products, square roots,
// divides and CORDIC for one corner. Depends on cta_pkg, cta_sqrt, cta_div,
// cta_cordic.
`timescale 1ns / 1ps

module cta_back
    import cta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        job,
    input  logic        job_empty,
    output logic        job_pop,
    input  logic [30:0] radius,
    output corner_t     res,
    output logic        res_valid,
    input  logic        res_ready
);

    back_state_t state_reg, state_next;
    logic [2:0]  idx_reg, idx_next;

    job_t               job_reg;
    logic [62:0]        nx_reg, ny_reg;
    logic               nxn_reg, nyn_reg;
    logic signed [30:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg, c3x_reg, c3y_reg;
    logic signed [62:0] dot_reg, cross_reg;
    logic [61:0]        sq1_reg, sq2_reg;
    logic [30:0]        n1_reg, n2_reg;
    logic signed [63:0] den_reg;
    logic [DIST_BITS-1:0] d_reg;
    logic signed [31:0] enx_reg, eny_reg, exx_reg, exy_reg;
    logic signed [15:0] hin_reg, hout_reg;
    logic signed [33:0] th_reg;
    logic [31:0]        arc_reg;
    logic               degen_reg;

    // normaliser
    logic [62:0]        nm;
    logic               norm_done;
    logic signed [30:0] norm_x, norm_y;
    logic [62:0]        ld_xm, ld_ym;
    logic               ld_xn, ld_yn;

    // shared multiplier
    logic signed [34:0] mul_a, mul_b;
    logic signed [69:0] mul_p;
    logic signed [62:0] p63;

    // units
    logic                 sq_start, sq_done;
    logic [61:0]          sq_value;
    logic [30:0]          sq_root;
    logic                 div_start, div_done;
    logic [62:0]          div_a, div_c;
    logic [QUOT_BITS-1:0] div_b;
    logic [DIST_BITS-1:0] div_q;
    logic                 cord_start, cord_done;
    logic signed [30:0]   cord_x, cord_y;
    logic signed [33:0]   cord_z;

    logic signed [41:0] off_v, off_s, base_v, coord_v;
    logic               off_neg, off_sub;
    logic signed [31:0] coord_sat;
    logic [64:0]        arc_sum;
    logic [34:0]        arc_shr;
    logic signed [34:0] th_pos;

    function automatic logic [62:0] abs33(input logic signed [32:0] v);
        abs33 = 63'(v < 0 ? -v : v);
    endfunction

    function automatic logic [62:0] abs63(input logic signed [62:0] v);
        abs63 = v < 0 ? 63'(-v) : 63'(v);
    endfunction

    function automatic logic [62:0] abs31(input logic signed [30:0] v);
        abs31 = 63'(v < 0 ? -v : v);
    endfunction

    function automatic logic signed [30:0] apply_sign(input logic [62:0] m, input logic neg);
        logic signed [30:0] p;
        p = $signed({1'b0, m[29:0]});
        apply_sign = neg ? -p : p;
    endfunction

    function automatic logic signed [15:0] heading_of(input logic signed [33:0] zq);
        logic signed [34:0] t;
        t = 35'(zq) + HEAD_HALF;
        heading_of = 16'(t >>> HEAD_SHIFT);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -42'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    cta_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .done  (sq_done),
        .root  (sq_root)
    );

    cta_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .c     (div_c),
        .done  (div_done),
        .q     (div_q)
    );

    cta_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  (cord_x),
        .y_in  (cord_y),
        .done  (cord_done),
        .z     (cord_z)
    );

    // normalise pair so the larger magnitude sits in [2^29, 2^30)
    assign nm        = (nx_reg > ny_reg) ? nx_reg : ny_reg;
    assign norm_done = (nm == '0) || (nm[62:30] == '0 && nm[29] == 1'b1);
    assign norm_x    = apply_sign(nx_reg, nxn_reg);
    assign norm_y    = apply_sign(ny_reg, nyn_reg);

    always_comb
    begin
        ld_xm = '0;
        ld_ym = '0;
        ld_xn = 1'b0;
        ld_yn = 1'b0;
        unique case (idx_reg)
            3'd0:
            begin
                ld_xm = abs33(job_reg.u1x);
                ld_ym = abs33(job_reg.u1y);
                ld_xn = job_reg.u1x < 0;
                ld_yn = job_reg.u1y < 0;
            end
            3'd1:
            begin
                ld_xm = abs33(job_reg.u2x);
                ld_ym = abs33(job_reg.u2y);
                ld_xn = job_reg.u2x < 0;
                ld_yn = job_reg.u2y < 0;
            end
            default:
            begin
                // angle between the legs: atan2(|cross|, dot)
                ld_xm = abs63(dot_reg);
                ld_ym = abs63(cross_reg);
                ld_xn = dot_reg < 0;
                ld_yn = 1'b0;
            end
        endcase
    end

    assign th_pos = th_reg[33] ? '0 : $signed({1'b0, th_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            BK_PROD:
            begin
                unique case (idx_reg)
                    3'd0: begin mul_a = 35'(s1x_reg); mul_b = 35'(s2x_reg); end
                    3'd1: begin mul_a = 35'(s1y_reg); mul_b = 35'(s2y_reg); end
                    3'd2: begin mul_a = 35'(s1x_reg); mul_b = 35'(s2y_reg); end
                    3'd3: begin mul_a = 35'(s1y_reg); mul_b = 35'(s2x_reg); end
                    3'd4: begin mul_a = 35'(s1x_reg); mul_b = 35'(s1x_reg); end
                    3'd5: begin mul_a = 35'(s1y_reg); mul_b = 35'(s1y_reg); end
                    3'd6: begin mul_a = 35'(s2x_reg); mul_b = 35'(s2x_reg); end
                    3'd7: begin mul_a = 35'(s2y_reg); mul_b = 35'(s2y_reg); end
                    default: ;
                endcase
            end
            BK_NN:
            begin
                mul_a = $signed({4'b0000, n1_reg});
                mul_b = $signed({4'b0000, n2_reg});
            end
            BK_ARC:
            begin
                mul_a = $signed({4'b0000, radius});
                mul_b = th_pos;
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign p63   = 63'(mul_p);

    assign sq_value = idx_reg[0] ? sq2_reg : sq1_reg;

    always_comb
    begin
        div_a   = '0;
        div_b   = {1'b0, d_reg};
        div_c   = 63'(n1_reg);
        off_neg = 1'b0;
        off_sub = 1'b1;
        base_v  = 42'(job_reg.bx);
        unique case (idx_reg)
            3'd0:
            begin
                div_a = abs63(cross_reg);
                div_b = QUOT_BITS'(radius);
                div_c = den_reg[62:0];
            end
            3'd1:
            begin
                div_a   = abs31(s1x_reg);
                off_neg = s1x_reg < 0;
            end
            3'd2:
            begin
                div_a   = abs31(s1y_reg);
                off_neg = s1y_reg < 0;
                base_v  = 42'(job_reg.by);
            end
            3'd3:
            begin
                div_a   = abs31(s2x_reg);
                div_c   = 63'(n2_reg);
                off_neg = s2x_reg < 0;
                off_sub = 1'b0;
            end
            3'd4:
            begin
                div_a   = abs31(s2y_reg);
                div_c   = 63'(n2_reg);
                off_neg = s2y_reg < 0;
                off_sub = 1'b0;
                base_v  = 42'(job_reg.by);
            end
            default: ;
        endcase
    end

    assign off_v     = $signed({2'b00, div_q});
    assign off_s     = off_neg ? -off_v : off_v;
    assign coord_v   = off_sub ? base_v - off_s : base_v + off_s;
    assign coord_sat = sat32(coord_v);

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    begin cord_x = s1x_reg; cord_y = s1y_reg; end
            3'd1:    begin cord_x = s2x_reg; cord_y = s2y_reg; end
            default: begin cord_x = c3x_reg; cord_y = c3y_reg; end
        endcase
    end

    // R * theta rounded from Q30, saturated to 32 bits
    assign arc_sum = {1'b0, mul_p[63:0]} + (65'd1 << 29);
    assign arc_shr = arc_sum[64:30];

    always_comb
    begin : next_state
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!job_empty) state_next = BK_CLASS;
            BK_CLASS:
            begin
                state_next = job_reg.degen ? BK_RES : BK_NORM_LD;
                idx_next   = 3'd0;
            end
            BK_NORM_LD:
                state_next = BK_NORM_RUN;
            BK_NORM_RUN:
                if (norm_done)
                begin
                    unique case (idx_reg)
                        3'd0:    begin state_next = BK_NORM_LD; idx_next = 3'd1; end
                        3'd1:    begin state_next = BK_PROD;    idx_next = 3'd0; end
                        default: state_next = BK_CORD_GO;
                    endcase
                end
            BK_PROD:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 3'd7)
                begin
                    state_next = BK_SQ_GO;
                    idx_next   = 3'd0;
                end
            end
            BK_SQ_GO:
                state_next = BK_SQ_WAIT;
            BK_SQ_WAIT:
                if (sq_done)
                begin
                    if (idx_reg == 3'd0)
                    begin
                        state_next = BK_SQ_GO;
                        idx_next   = 3'd1;
                    end
                    else
                    begin
                        state_next = BK_NN;
                    end
                end
            BK_NN:
                state_next = BK_DEN;
            BK_DEN:
            begin
                state_next = (den_reg <= 0) ? BK_RES : BK_DIV_GO;
                idx_next   = 3'd0;
            end
            BK_DIV_GO:
                state_next = BK_DIV_WAIT;
            BK_DIV_WAIT:
                if (div_done)
                begin
                    if (idx_reg == 3'd4)
                    begin
                        state_next = BK_CORD_GO;
                        idx_next   = 3'd0;
                    end
                    else
                    begin
                        state_next = BK_DIV_GO;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
            BK_CORD_GO:
                state_next = BK_CORD_WAIT;
            BK_CORD_WAIT:
                if (cord_done)
                begin
                    unique case (idx_reg)
                        3'd0:    begin state_next = BK_CORD_GO; idx_next = 3'd1; end
                        3'd1:    begin state_next = BK_NORM_LD; idx_next = 3'd2; end
                        default: state_next = BK_ARC;
                    endcase
                end
            BK_ARC:
                state_next = BK_RES;
            BK_RES:
                if (res_ready) state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin : outputs
        job_pop    = (state_reg == BK_IDLE) && !job_empty;
        sq_start   = (state_reg == BK_SQ_GO);
        div_start  = (state_reg == BK_DIV_GO);
        cord_start = (state_reg == BK_CORD_GO);
        res_valid  = (state_reg == BK_RES);
    end

    always_comb
    begin
        res = '0;
        if (degen_reg)
        begin
            res.degenerate = 1'b1;
        end
        else
        begin
            res.entry_x     = enx_reg;
            res.entry_y     = eny_reg;
            res.exit_x      = exx_reg;
            res.exit_y      = exy_reg;
            res.heading_in  = hin_reg;
            res.heading_out = hout_reg;
            res.arc_length  = arc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
                job_reg <= job;
            BK_CLASS:
                degen_reg <= job_reg.degen;
            BK_NORM_LD:
            begin
                nx_reg  <= ld_xm;
                ny_reg  <= ld_ym;
                nxn_reg <= ld_xn;
                nyn_reg <= ld_yn;
            end
            BK_NORM_RUN:
            begin
                if (norm_done)
                begin
                    unique case (idx_reg)
                        3'd0:    begin s1x_reg <= norm_x; s1y_reg <= norm_y; end
                        3'd1:    begin s2x_reg <= norm_x; s2y_reg <= norm_y; end
                        default: begin c3x_reg <= norm_x; c3y_reg <= norm_y; end
                    endcase
                end
                else if (nm[62:30] != '0)
                begin
                    nx_reg <= {1'b0, nx_reg[62:1]};
                    ny_reg <= {1'b0, ny_reg[62:1]};
                end
                else
                begin
                    nx_reg <= {nx_reg[61:0], 1'b0};
                    ny_reg <= {ny_reg[61:0], 1'b0};
                end
            end
            BK_PROD:
            begin
                unique case (idx_reg)
                    3'd0: dot_reg   <= p63;
                    3'd1: dot_reg   <= dot_reg + p63;
                    3'd2: cross_reg <= p63;
                    3'd3: cross_reg <= cross_reg - p63;
                    3'd4: sq1_reg   <= 62'(mul_p);
                    3'd5: sq1_reg   <= sq1_reg + 62'(mul_p);
                    3'd6: sq2_reg   <= 62'(mul_p);
                    3'd7: sq2_reg   <= sq2_reg + 62'(mul_p);
                    default: ;
                endcase
            end
            BK_SQ_WAIT:
            begin
                if (sq_done)
                begin
                    if (idx_reg == 3'd0)
                        n1_reg <= sq_root;
                    else
                        n2_reg <= sq_root;
                end
            end
            BK_NN:
                den_reg <= 64'(mul_p) + 64'(dot_reg);
            BK_DEN:
                if (den_reg <= 0) degen_reg <= 1'b1;
            BK_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (idx_reg)
                        3'd0:    d_reg   <= div_q;
                        3'd1:    enx_reg <= coord_sat;
                        3'd2:    eny_reg <= coord_sat;
                        3'd3:    exx_reg <= coord_sat;
                        3'd4:    exy_reg <= coord_sat;
                        default: ;
                    endcase
                end
            end
            BK_CORD_WAIT:
            begin
                if (cord_done)
                begin
                    unique case (idx_reg)
                        3'd0:    hin_reg  <= heading_of(cord_z);
                        3'd1:    hout_reg <= heading_of(cord_z);
                        default: th_reg   <= cord_z;
                    endcase
                end
            end
            BK_ARC:
                arc_reg <= (arc_shr[34:32] != '0) ? 32'hFFFFFFFF : arc_shr[31:0];
            default: ;
        endcase
    end

endmodule

[design/corner_tangent_arc.sv]
// corner_tangent_arc: top level; radius register, front, job queue, back
// and result register. Depends on cta_pkg, cta_front, cta_queue, cta_back.
//
// Use: waypoints enter as beats on wp with push/full; corner results leave
// as beats on res with empty/pop. The oldest result sits on res while empty
// is low. path_start on a beat starts a new path; the first two waypoints of
// a path give no result, every later one gives one corner result.
// radius_we writes radius_wdata into the turn radius; write only when idle.
// The front takes a beat in any cycle with push high and full low. A
// corner whose legs are not coincident spends most of its time in the
// back in the serial multiply-divide unit, which runs five times per
// corner; coincident legs go from classification straight to the result.
// A two-entry job queue sits between front and back, so waypoints keep
// being taken while a corner is worked on or a result waits.
// Reset clears the waypoint window, the queue, the result register and sets
// the radius to 1.0. When pop stays low the finished result is held, the
// back waits on it, the queue fills and full rises.
`timescale 1ns / 1ps

module corner_tangent_arc
    import cta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  waypoint_t   wp,
    input  logic        push,
    output logic        full,
    input  logic        radius_we,
    input  logic [30:0] radius_wdata,
    output corner_t     res,
    output logic        empty,
    input  logic        pop
);

    logic [30:0] radius_reg;
    logic        job_push, q_full, q_empty, job_pop;
    job_t        job_in, job_head;
    corner_t     back_res, out_reg;
    logic        back_valid, back_ready, out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (radius_we)
        begin
            radius_reg <= radius_wdata;
        end
    end

    cta_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wp       (wp),
        .push     (push),
        .full     (full),
        .q_full   (q_full),
        .job_push (job_push),
        .job      (job_in)
    );

    cta_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (job_push),
        .push_data (job_in),
        .full      (q_full),
        .pop_en    (job_pop),
        .head      (job_head),
        .empty     (q_empty)
    );

    cta_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_empty (q_empty),
        .job_pop   (job_pop),
        .radius    (radius_reg),
        .res       (back_res),
        .res_valid (back_valid),
        .res_ready (back_ready)
    );

    // result register frees in the same cycle its beat is popped
    assign back_ready = !out_valid_reg || pop;
    assign empty      = !out_valid_reg;
    assign res        = out_reg;

    always_ff @(posedge clk)
    begin
        if (back_valid && back_ready)
        begin
            out_reg <= back_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (back_valid && back_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
